@@ design/dbr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dbr_pkg: shared types and constants of the button / RGB animator
// Register indexes, LED modes, the interface structs of the shared divider
// and the debouncer, and the channel select helper.
// ----------------------------------------------------------------------------
package dbr_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STATIC_COLOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_A      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_B      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_A       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_B       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS  = 3'd6;

    localparam int unsigned CFG_DATA_W = 24;

    // LED modes
    localparam logic [1:0] MODE_STATIC = 2'd0;
    localparam logic [1:0] MODE_BLINK  = 2'd1;
    localparam logic [1:0] MODE_FADE   = 2'd2;

    localparam logic [15:0] DEBOUNCE_RESET = 16'd20;

    // color channels, in the order the fade walks them
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // shared divider geometry
    localparam int unsigned DIV_DW = 32;  // dividend / quotient
    localparam int unsigned DIV_RW = 17;  // divisor / remainder
    localparam int unsigned DIV_CW = 6;   // step count
    localparam logic [DIV_CW-1:0] DIV_STEPS_MOD  = 6'd32;
    localparam logic [DIV_CW-1:0] DIV_STEPS_FADE = 6'd8;

    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [DIV_RW-1:0] rem_init;
        logic [DIV_RW-1:0] divisor;
        logic [DIV_CW-1:0] steps;
    } dbr_div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_DW-1:0] quot;
        logic [DIV_RW-1:0] rem;
    } dbr_div_rsp_t;

    typedef struct packed {
        logic        pressed;
        logic        pushed;
        logic        released;
        logic [31:0] press_time;
        logic [31:0] release_time;
    } dbr_btn_t;

    function automatic logic [7:0] chan_sel(input logic [23:0] color,
                                            input logic [1:0]  idx);
        logic [7:0] res;
        unique case (idx)
            CH_RED:   res = color[23:16];
            CH_GREEN: res = color[15:8];
            default:  res = color[7:0];
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

@@ design/dbr_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dbr_div: shared iterative restoring divider
// One quotient bit per cycle. Remainder starts at rem_init, dividend bits are
// shifted in MSB first for 'steps' steps; done pulses after the last step.
// ----------------------------------------------------------------------------
module dbr_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dbr_pkg::dbr_div_req_t req,
    output dbr_pkg::dbr_div_rsp_t rsp
);
    import dbr_pkg::*;

    localparam logic [DIV_CW-1:0] CNT_ONE = {{(DIV_CW-1){1'b0}}, 1'b1};

    logic [DIV_RW-1:0] rem_reg, rem_next;
    logic [DIV_DW-1:0] quot_reg, quot_next;
    logic [DIV_RW-1:0] div_reg, div_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DIV_RW:0]   shifted;
    logic [DIV_RW:0]   diff;
    logic              fits;

    assign shifted = {rem_reg, quot_reg[DIV_DW-1]};
    assign fits    = (shifted >= {1'b0, div_reg});
    assign diff    = shifted - {1'b0, div_reg};

    always_comb begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = req.rem_init;
            quot_next = req.dividend;
            div_next  = req.divisor;
            cnt_next  = req.steps;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = fits ? diff[DIV_RW-1:0] : shifted[DIV_RW-1:0];
            quot_next = {quot_reg[DIV_DW-2:0], fits};
            cnt_next  = cnt_reg - CNT_ONE;
            if (cnt_reg == CNT_ONE) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        div_reg  <= div_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule
`default_nettype wire

@@ design/dbr_btn.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dbr_btn: button debouncer and edge timestamps
// Updates once per accepted tick; state holds between ticks.
// ----------------------------------------------------------------------------
module dbr_btn (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             tick,
    input  logic             raw_pin,
    input  logic [31:0]      now,
    input  logic [15:0]      debounce_ms,
    output dbr_pkg::dbr_btn_t st
);
    import dbr_pkg::*;

    logic        raw_last_reg, raw_last_next;
    logic [31:0] change_time_reg, change_time_next;
    logic        debounced_reg, debounced_next;
    logic        pushed_reg, pushed_next;
    logic        released_reg, released_next;
    logic [31:0] press_time_reg, press_time_next;
    logic [31:0] release_time_reg, release_time_next;

    logic        level;   // 1 = pressed
    logic        changed;
    logic [31:0] held;

    assign level   = ~raw_pin;
    assign changed = (level != raw_last_reg);
    assign held    = now - change_time_reg;

    always_comb begin
        raw_last_next     = raw_last_reg;
        change_time_next  = change_time_reg;
        debounced_next    = debounced_reg;
        pushed_next       = pushed_reg;
        released_next     = released_reg;
        press_time_next   = press_time_reg;
        release_time_next = release_time_reg;
        if (tick) begin
            raw_last_next = level;
            if (changed) begin
                change_time_next = now;
            end
            // a fresh change has held zero ticks, never longer than the limit
            if (!changed && (held > {16'd0, debounce_ms})) begin
                debounced_next = level;
            end
            pushed_next   = debounced_next & ~debounced_reg;
            released_next = ~debounced_next & debounced_reg;
            if (pushed_next) begin
                press_time_next = now;
            end
            if (released_next) begin
                release_time_next = now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_last_reg     <= 1'b0;
            change_time_reg  <= '0;
            debounced_reg    <= 1'b0;
            pushed_reg       <= 1'b0;
            released_reg     <= 1'b0;
            press_time_reg   <= '0;
            release_time_reg <= '0;
        end else begin
            raw_last_reg     <= raw_last_next;
            change_time_reg  <= change_time_next;
            debounced_reg    <= debounced_next;
            pushed_reg       <= pushed_next;
            released_reg     <= released_next;
            press_time_reg   <= press_time_next;
            release_time_reg <= release_time_next;
        end
    end

    assign st.pressed      = debounced_reg;
    assign st.pushed       = pushed_reg;
    assign st.released     = released_reg;
    assign st.press_time   = press_time_reg;
    assign st.release_time = release_time_reg;

endmodule
`default_nettype wire

@@ design/debounced_button_rgb_animator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// debounced_button_rgb_animator: debounced button plus RGB blink / fade driver
// One input beat per millisecond tick; one result beat per input beat.
// ----------------------------------------------------------------------------
// Each input beat is one millisecond tick carrying the active-low button pin
// and an animation restart flag; each produces exactly one result beat with
// inverted 8-bit RGB duties, the debounced button state, push/release strobes
// and the wrapping tick counts since the last push and release. One tick is
// worked on at a time and s_ready is low until its result is staged in the
// output register (a staged result may still wait on m_ready while the next
// tick is taken). Divisions run on one shared restoring divider that yields a
// bit per cycle: static mode needs none, blink a 32-step modulo of animation
// time by time_a+time_b, fade the modulo plus three 8-step divisions for the
// per-channel interpolation, each preceded by a 16x8 multiply. Configuration
// writes are always accepted (cfg_ready is tied high) and must only be issued
// while the block is idle; indexes above 6 are ignored.
// ----------------------------------------------------------------------------
module debounced_button_rgb_animator (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,

    // tick channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_raw_pin,
    input  logic        s_restart_animation,

    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_pwm_red,
    output logic [7:0]  m_pwm_green,
    output logic [7:0]  m_pwm_blue,
    output logic        m_pressed,
    output logic        m_just_pushed,
    output logic        m_just_released,
    output logic [31:0] m_ms_since_pressed,
    output logic [31:0] m_ms_since_released
);
    import dbr_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_MOD_GO   = 3'd1;
    localparam logic [2:0] S_MOD_WAIT = 3'd2;
    localparam logic [2:0] S_MUL      = 3'd3;
    localparam logic [2:0] S_DIV_GO   = 3'd4;
    localparam logic [2:0] S_DIV_WAIT = 3'd5;
    localparam logic [2:0] S_OUT      = 3'd6;

    // ---------------- configuration registers ----------------
    logic [1:0]  led_mode_reg;
    logic [23:0] static_color_reg, color_a_reg, color_b_reg;
    logic [15:0] time_a_reg, time_b_reg, debounce_ms_reg;
    logic        cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid & cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            led_mode_reg     <= MODE_STATIC;
            static_color_reg <= '0;
            color_a_reg      <= '0;
            color_b_reg      <= '0;
            time_a_reg       <= '0;
            time_b_reg       <= '0;
            debounce_ms_reg  <= DEBOUNCE_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                CFG_LED_MODE:     led_mode_reg     <= cfg_data[1:0];
                CFG_STATIC_COLOR: static_color_reg <= cfg_data;
                CFG_COLOR_A:      color_a_reg      <= cfg_data;
                CFG_COLOR_B:      color_b_reg      <= cfg_data;
                CFG_TIME_A:       time_a_reg       <= cfg_data[15:0];
                CFG_TIME_B:       time_b_reg       <= cfg_data[15:0];
                CFG_DEBOUNCE_MS:  debounce_ms_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // ---------------- state ----------------
    logic [2:0]  state_reg, state_next;
    logic [31:0] tick_count_reg, tick_count_next;
    logic [31:0] anim_start_reg, anim_start_next;
    logic [31:0] item_now_reg, item_now_next;
    logic [31:0] elapsed_reg, elapsed_next;   // animation time of this tick
    logic [16:0] t_reg, t_next;               // position inside the period
    logic [1:0]  ch_reg, ch_next;
    logic [23:0] prod_reg, prod_next;
    logic [7:0]  y0_reg, y0_next;
    logic        neg_reg, neg_next;
    logic [15:0] den_reg, den_next;
    logic [23:0] color_reg, color_next;

    logic        m_valid_reg, m_valid_next;
    logic [7:0]  pwm_red_reg, pwm_green_reg, pwm_blue_reg;
    logic        pressed_reg, pushed_reg, released_reg;
    logic [31:0] since_press_reg, since_release_reg;

    logic        accept;
    logic        animating;
    logic [16:0] period;
    logic        out_load;

    dbr_div_req_t div_req;
    dbr_div_rsp_t div_rsp;
    dbr_btn_t     btn;

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid & s_ready;
    assign period    = {1'b0, time_a_reg} + {1'b0, time_b_reg};
    assign animating = ((led_mode_reg == MODE_BLINK) || (led_mode_reg == MODE_FADE))
                       && (period != '0);
    assign out_load  = (state_reg == S_OUT) && (!m_valid_reg || m_ready);

    // ---------------- submodules ----------------
    dbr_btn u_btn (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .tick        (accept),
        .raw_pin     (s_raw_pin),
        .now         (tick_count_reg),
        .debounce_ms (debounce_ms_reg),
        .st          (btn)
    );

    dbr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // ---------------- fade channel datapath ----------------
    logic        seg_a;        // t falls in the A-to-B segment
    logic [16:0] t_minus_a;
    logic [15:0] x_off;
    logic [7:0]  ca, cb, y0, y1, mag;
    logic        neg;
    logic [7:0]  q;
    logic [7:0]  v;

    assign seg_a     = (t_reg < {1'b0, time_a_reg});
    assign t_minus_a = t_reg - {1'b0, time_a_reg};
    assign x_off     = seg_a ? t_reg[15:0] : t_minus_a[15:0];
    assign ca        = chan_sel(color_a_reg, ch_reg);
    assign cb        = chan_sel(color_b_reg, ch_reg);
    assign y0        = seg_a ? ca : cb;
    assign y1        = seg_a ? cb : ca;
    assign neg       = (y1 < y0);
    assign mag       = neg ? (y0 - y1) : (y1 - y0);
    // x_off < den, so the quotient stays below mag: no clamp needed
    assign q         = div_rsp.quot[7:0];
    assign v         = neg_reg ? (y0_reg - q) : (y0_reg + q);

    // ---------------- sequencer ----------------
    always_comb begin
        state_next      = state_reg;
        tick_count_next = tick_count_reg;
        anim_start_next = anim_start_reg;
        item_now_next   = item_now_reg;
        elapsed_next    = elapsed_reg;
        t_next          = t_reg;
        ch_next         = ch_reg;
        prod_next       = prod_reg;
        y0_next         = y0_reg;
        neg_next        = neg_reg;
        den_next        = den_reg;
        color_next      = color_reg;

        div_req          = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    item_now_next   = tick_count_reg;
                    tick_count_next = tick_count_reg + 32'd1;
                    if (s_restart_animation) begin
                        anim_start_next = tick_count_reg;
                        elapsed_next    = '0;
                    end else begin
                        elapsed_next    = tick_count_reg - anim_start_reg;
                    end
                    if (animating) begin
                        state_next = S_MOD_GO;
                    end else begin
                        // zero period shows A; static and unused modes show static
                        color_next = ((led_mode_reg == MODE_BLINK) ||
                                      (led_mode_reg == MODE_FADE))
                                     ? color_a_reg : static_color_reg;
                        state_next = S_OUT;
                    end
                end
            end
            S_MOD_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = elapsed_reg;
                div_req.rem_init = '0;
                div_req.divisor  = period;
                div_req.steps    = DIV_STEPS_MOD;
                state_next       = S_MOD_WAIT;
            end
            S_MOD_WAIT: begin
                if (div_rsp.done) begin
                    t_next = div_rsp.rem;
                    if (led_mode_reg == MODE_BLINK) begin
                        color_next = (div_rsp.rem < {1'b0, time_a_reg})
                                     ? color_a_reg : color_b_reg;
                        state_next = S_OUT;
                    end else begin
                        ch_next    = CH_RED;
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL: begin
                prod_next  = {8'd0, x_off} * {16'd0, mag};
                y0_next    = y0;
                neg_next   = neg;
                den_next   = seg_a ? time_a_reg : time_b_reg;
                state_next = S_DIV_GO;
            end
            S_DIV_GO: begin
                // product < den * 256, so its top 16 bits seed the remainder
                // and only 8 quotient bits remain
                div_req.start    = 1'b1;
                div_req.dividend = {prod_reg[7:0], 24'd0};
                div_req.rem_init = {1'b0, prod_reg[23:8]};
                div_req.divisor  = {1'b0, den_reg};
                div_req.steps    = DIV_STEPS_FADE;
                state_next       = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_rsp.done) begin
                    unique case (ch_reg)
                        CH_RED:   color_next[23:16] = v;
                        CH_GREEN: color_next[15:8]  = v;
                        default:  color_next[7:0]   = v;
                    endcase
                    if (ch_reg == CH_BLUE) begin
                        state_next = S_OUT;
                    end else begin
                        ch_next    = ch_reg + 2'd1;
                        state_next = S_MUL;
                    end
                end
            end
            S_OUT: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            tick_count_reg <= '0;
            anim_start_reg <= '0;
            ch_reg         <= CH_RED;
        end else begin
            state_reg      <= state_next;
            tick_count_reg <= tick_count_next;
            anim_start_reg <= anim_start_next;
            ch_reg         <= ch_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_now_reg <= item_now_next;
        elapsed_reg  <= elapsed_next;
        t_reg        <= t_next;
        prod_reg     <= prod_next;
        y0_reg       <= y0_next;
        neg_reg      <= neg_next;
        den_reg      <= den_next;
        color_reg    <= color_next;
    end

    // ---------------- output register ----------------
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            pwm_red_reg       <= ~color_reg[23:16];   // 255 - component
            pwm_green_reg     <= ~color_reg[15:8];
            pwm_blue_reg      <= ~color_reg[7:0];
            pressed_reg       <= btn.pressed;
            pushed_reg        <= btn.pushed;
            released_reg      <= btn.released;
            since_press_reg   <= item_now_reg - btn.press_time;
            since_release_reg <= item_now_reg - btn.release_time;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_pwm_red           = pwm_red_reg;
    assign m_pwm_green         = pwm_green_reg;
    assign m_pwm_blue          = pwm_blue_reg;
    assign m_pressed           = pressed_reg;
    assign m_just_pushed       = pushed_reg;
    assign m_just_released     = released_reg;
    assign m_ms_since_pressed  = since_press_reg;
    assign m_ms_since_released = since_release_reg;

    // ---------------- assertions ----------------
    // no new tick while the shared divider is still working
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.busy |-> !s_ready)
        else $error("tick channel ready while divider busy");

    // one tick at a time: ready drops right after a beat is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second tick accepted back to back");

    // push and release strobes never coincide
    a_edges_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_just_pushed && m_just_released))
        else $error("push and release reported on the same tick");

    // a push strobe always comes with the pressed state
    a_push_pressed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_just_pushed) |-> m_pressed)
        else $error("push reported while not pressed");

endmodule
`default_nettype wire
